>>> sv/sled_pkg.sv
// Shared types and constants for the status LED pattern generator.
// No dependencies; used by sled_div and status_led_pattern_generator.
`timescale 1ns / 1ps

package sled_pkg;

  // timing constants in milliseconds, then full scale and reset brightness
  localparam int unsigned AcceptGapMs  = 20;
  localparam int unsigned FlashPeriod  = 600;
  localparam int unsigned LinkedPeriod = 2500;
  localparam int unsigned BlinkHalf    = 250;
  localparam int unsigned StaPeriod    = 4000;
  localparam int unsigned ApPeriod     = 5000;
  localparam int unsigned IdlePeriod   = 6000;
  localparam int unsigned FullScale    = 255;
  localparam int unsigned BrightReset  = 24;

  // divider geometry
  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 13;   // holds the longest period
  localparam int unsigned HalfW     = 12;   // holds half of the longest period
  localparam int unsigned NumW      = HalfW + 8;  // folded time times full scale
  localparam int unsigned CountW    = 6;

  // wireless mode codes
  localparam logic [1:0] MODE_CLIENT = 2'd1;
  localparam logic [1:0] MODE_AP     = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        flashing;
    logic        link_running;
    logic        link_connected;
    logic [1:0]  wireless_mode;
  } tick_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_t;

  // request into the shared divider
  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
    logic [CountW-1:0]    count;
  } div_req_t;

  // divider result, done is a one-cycle pulse
  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

  // x / 255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

>>> sv/sled_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sled_pkg for request/response types and widths.
`timescale 1ns / 1ps

module sled_div (
  input  logic                clk,
  input  logic                rst,
  input  sled_pkg::div_req_t  req,
  output sled_pkg::div_rsp_t  rsp
);

  logic [sled_pkg::DivisorW-1:0]  rem;
  logic [sled_pkg::DividendW-1:0] quo;
  logic [sled_pkg::DivisorW-1:0]  dvs;
  logic [sled_pkg::CountW-1:0]    cnt;
  logic                           busy;
  logic                           done;

  logic [sled_pkg::DivisorW:0] trial;
  logic [sled_pkg::DivisorW:0] dvs_ext;
  logic                        ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem, quo[sled_pkg::DividendW-1]};
    dvs_ext = {1'b0, dvs};
    ge      = (trial >= dvs_ext);
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= req.count;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= sled_pkg::DivisorW'(trial - dvs_ext);
        end else begin
          rem <= trial[sled_pkg::DivisorW-1:0];
        end
        quo <= {quo[sled_pkg::DividendW-2:0], ge};
        cnt <= cnt - sled_pkg::CountW'(1);
        if (cnt == sled_pkg::CountW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> sv/status_led_pattern_generator.sv
// Status LED pattern generator: ticks in, scaled RGB colours out.
// Once a tick request is taken, a 32-step divide finds the phase, a 20-step divide
// finds the wave value (skipped for the red blink), then brightness scales the three
// channels in turn on one shared multiplier; led_valid rises if the colour changed.
// One tick at a time: the next tick is taken only once the block is back in idle,
// which a colour waiting on led_stall delays. An early tick is dropped in the cycle it is
// taken. Synchronous reset sets brightness to 24 and clears the last time and last colour.
`timescale 1ns / 1ps

module status_led_pattern_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  sled_pkg::tick_t     tick,
  output logic                led_valid,
  input  logic                led_stall,
  output sled_pkg::led_t      led,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);

  typedef enum logic [2:0] {
    PAT_FLASH,
    PAT_LINKED,
    PAT_BLINK,
    PAT_STA,
    PAT_AP,
    PAT_IDLE
  } pat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_WAVE_GO,
    S_WAVE,
    S_COLOR,
    S_DIM,
    S_CMP
  } state_t;

  state_t state;
  pat_t   pat;
  logic [7:0]  brightness;
  logic [31:0] last_accept_time;
  logic [7:0]  last_red;
  logic [7:0]  last_green;
  logic [7:0]  last_blue;
  logic [sled_pkg::HalfW-1:0] fold;
  logic [sled_pkg::DivisorW-1:0] period;
  logic [7:0]  v;
  logic [7:0]  chan [3];
  logic [7:0]  dimmed [3];
  logic [1:0]  idx;

  sled_pkg::div_req_t div_req;
  sled_pkg::div_rsp_t div_rsp;

  // pattern choice by priority
  function automatic pat_t pick(input sled_pkg::tick_t t);
    priority if (t.flashing) begin
      return PAT_FLASH;
    end else if (t.link_running && t.link_connected) begin
      return PAT_LINKED;
    end else if (t.link_running) begin
      return PAT_BLINK;
    end else if (t.wireless_mode == sled_pkg::MODE_CLIENT) begin
      return PAT_STA;
    end else if (t.wireless_mode == sled_pkg::MODE_AP) begin
      return PAT_AP;
    end else begin
      return PAT_IDLE;
    end
  endfunction

  // divisor of the first divide for each pattern
  function automatic logic [sled_pkg::DivisorW-1:0] period_of(input pat_t p);
    unique case (p)
      PAT_FLASH:  return sled_pkg::DivisorW'(sled_pkg::FlashPeriod);
      PAT_LINKED: return sled_pkg::DivisorW'(sled_pkg::LinkedPeriod);
      PAT_BLINK:  return sled_pkg::DivisorW'(sled_pkg::BlinkHalf);
      PAT_STA:    return sled_pkg::DivisorW'(sled_pkg::StaPeriod);
      PAT_AP:     return sled_pkg::DivisorW'(sled_pkg::ApPeriod);
      default:    return sled_pkg::DivisorW'(sled_pkg::IdlePeriod);
    endcase
  endfunction

  // early tick check by wrapping difference
  logic [31:0] gap;
  logic        accept;
  logic        take;
  assign gap        = tick.now_ms - last_accept_time;
  assign tick_stall = (state != S_IDLE);
  assign accept     = tick_valid && !tick_stall;
  assign take       = accept && (gap >= 32'(sled_pkg::AcceptGapMs));

  // fold of the phase onto the rising half
  logic [sled_pkg::HalfW-1:0]    half;
  logic [sled_pkg::DivisorW-1:0] phase;
  logic [sled_pkg::HalfW-1:0]    fold_next;
  always_comb begin
    half  = period[sled_pkg::DivisorW-1:1];
    phase = div_rsp.remainder;
    if (phase < {1'b0, half}) begin
      fold_next = phase[sled_pkg::HalfW-1:0];
    end else begin
      fold_next = sled_pkg::HalfW'(period - phase);
    end
  end

  // folded phase times full scale: (fold << 8) - fold
  logic [sled_pkg::NumW-1:0] num;
  assign num = {fold, 8'd0} - {8'd0, fold};

  // divider request
  always_comb begin
    div_req = '0;
    if (state == S_IDLE && take) begin
      div_req.start    = 1'b1;
      div_req.dividend = tick.now_ms;
      div_req.divisor  = period_of(pick(tick));
      div_req.count    = sled_pkg::CountW'(sled_pkg::DividendW);
    end else if (state == S_WAVE_GO) begin
      div_req.start    = 1'b1;
      div_req.dividend = {num, (sled_pkg::DividendW - sled_pkg::NumW)'(0)};
      div_req.divisor  = {1'b0, half};
      div_req.count    = sled_pkg::CountW'(sled_pkg::NumW);
    end
  end

  sled_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // v / 3 by reciprocal, v / 6 as half of that
  logic [16:0] third_prod;
  logic [7:0]  v3;
  logic [7:0]  v6;
  assign third_prod = {9'd0, v} * 17'd171;
  assign v3 = third_prod[16:9];
  assign v6 = {1'b0, v3[7:1]};

  // brightness scaling on the shared multiplier
  logic [15:0] scale_prod;
  assign scale_prod = {8'd0, chan[idx]} * {8'd0, brightness};

  logic same;
  assign same = (dimmed[0] == last_red) && (dimmed[1] == last_green) &&
                (dimmed[2] == last_blue);

  // new colour loads when the output register is free or being emptied
  logic led_load;
  assign led_load = (state == S_CMP) && !same && (!led_valid || !led_stall);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 8'(sled_pkg::BrightReset);
    end else if (cfg_we) begin
      brightness <= cfg_data;
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      led_valid        <= 1'b0;
      last_accept_time <= '0;
      last_red         <= '0;
      last_green       <= '0;
      last_blue        <= '0;
    end else begin
      if (led_load) begin
        led_valid <= 1'b1;
      end else if (led_valid && !led_stall) begin
        led_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            last_accept_time <= tick.now_ms;
            pat              <= pick(tick);
            period           <= period_of(pick(tick));
            state            <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (div_rsp.done) begin
            if (pat == PAT_BLINK) begin
              v     <= div_rsp.quotient[0] ? 8'(sled_pkg::FullScale) : 8'd0;
              state <= S_COLOR;
            end else begin
              fold  <= fold_next;
              state <= S_WAVE_GO;
            end
          end
        end
        S_WAVE_GO: begin
          state <= S_WAVE;
        end
        S_WAVE: begin
          if (div_rsp.done) begin
            v     <= div_rsp.quotient[7:0];
            state <= S_COLOR;
          end
        end
        S_COLOR: begin
          unique case (pat)
            PAT_FLASH: begin
              chan[0] <= v; chan[1] <= v; chan[2] <= 8'd0;
            end
            PAT_LINKED: begin
              chan[0] <= 8'd0; chan[1] <= v; chan[2] <= v;
            end
            PAT_BLINK: begin
              chan[0] <= v; chan[1] <= 8'd0; chan[2] <= 8'd0;
            end
            PAT_STA: begin
              chan[0] <= 8'd0; chan[1] <= v; chan[2] <= 8'd0;
            end
            PAT_AP: begin
              chan[0] <= v3; chan[1] <= 8'd0; chan[2] <= v;
            end
            default: begin
              chan[0] <= v6; chan[1] <= v6; chan[2] <= v6;
            end
          endcase
          idx   <= 2'd0;
          state <= S_DIM;
        end
        S_DIM: begin
          dimmed[idx] <= sled_pkg::div255(scale_prod);
          idx         <= idx + 2'd1;
          if (idx == 2'd2) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (same) begin
            state <= S_IDLE;
          end else if (led_load) begin
            led.red    <= dimmed[0];
            led.green  <= dimmed[1];
            led.blue   <= dimmed[2];
            last_red   <= dimmed[0];
            last_green <= dimmed[1];
            last_blue  <= dimmed[2];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/status_led_pattern_generator_tb.sv
// Self-checking testbench for the status LED pattern generator.
// Depends on sled_pkg (tick and colour types, timing constants) and the RTL top.
// Directed table first, then four random phases with different idle, stall and brightness.
`timescale 1ns / 1ps

module status_led_pattern_generator_tb;

  localparam int unsigned SettleCycles  = 100;   // covers the longest tick-to-colour path
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ItemsPerPhase = 332;
  localparam int          NumRows       = 26;

  // wireless mode codes the package leaves unnamed, plus short local names
  localparam logic [1:0] ModeNone   = 2'd0;
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam logic [1:0] ModeClient = sled_pkg::MODE_CLIENT;
  localparam logic [1:0] ModeAp     = sled_pkg::MODE_AP;

  typedef enum logic {ROW_TICK, ROW_LEVEL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  level;
    logic [31:0] now;
    logic        fl;
    logic        run;
    logic        conn;
    logic [1:0]  mode;
    logic        typed;
    logic        emits;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } plan_row_t;

  // directed stimulus; typed rows carry their colour, the rest go through the predictor
  plan_row_t plan [NumRows] = '{
    // early ticks right after reset, then the first accepted one at reset brightness
    '{ROW_TICK,  8'd0,   32'd0,          1'b0, 1'b0, 1'b0, ModeNone,  1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd19,         1'b1, 1'b0, 1'b0, ModeNone,  1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd20,         1'b1, 1'b0, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd1, 8'd1, 8'd0},
    '{ROW_TICK,  8'd0,   32'd40,         1'b1, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_LEVEL, 8'd255, 32'd0,          1'b0, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    // every pattern at its peak or at its edges, full brightness
    '{ROW_TICK,  8'd0,   32'd300,        1'b1, 1'b0, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd255, 8'd255, 8'd0},
    '{ROW_TICK,  8'd0,   32'd320,        1'b0, 1'b1, 1'b1, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd1250,       1'b0, 1'b1, 1'b1, ModeNone,  1'b1, 1'b1,
      8'd0, 8'd255, 8'd255},
    '{ROW_TICK,  8'd0,   32'd1500,       1'b0, 1'b1, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd1750,       1'b0, 1'b1, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd255, 8'd0, 8'd0},
    // same colour: time is stored, so the next tick 10 ms later is early
    '{ROW_TICK,  8'd0,   32'd1770,       1'b0, 1'b1, 1'b0, ModeNone,  1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd1780,       1'b0, 1'b1, 1'b0, ModeNone,  1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    // connected flag without a running link is ignored
    '{ROW_TICK,  8'd0,   32'd2000,       1'b0, 1'b0, 1'b1, ModeClient, 1'b1, 1'b1,
      8'd0, 8'd255, 8'd0},
    '{ROW_TICK,  8'd0,   32'd2500,       1'b0, 1'b0, 1'b0, ModeAp,    1'b1, 1'b1,
      8'd85, 8'd0, 8'd255},
    // unused mode behaves as idle
    '{ROW_TICK,  8'd0,   32'd3000,       1'b0, 1'b0, 1'b0, ModeSpare, 1'b1, 1'b1,
      8'd42, 8'd42, 8'd42},
    '{ROW_TICK,  8'd0,   32'd3020,       1'b0, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd6000,       1'b0, 1'b0, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd0, 8'd0, 8'd0},
    // flashing wins over everything; black again is not re-sent
    '{ROW_TICK,  8'd0,   32'd6600,       1'b1, 1'b1, 1'b1, ModeAp,    1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd6900,       1'b1, 1'b0, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd255, 8'd255, 8'd0},
    // timestamp wrap: 19 ms across the wrap is early, 20 ms is not
    '{ROW_TICK,  8'd0,   32'hFFFF_FFF0,  1'b1, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd3,          1'b1, 1'b0, 1'b0, ModeNone,  1'b1, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd4,          1'b1, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, ModeSpare, 1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    // zero brightness turns everything black
    '{ROW_LEVEL, 8'd0,   32'd0,          1'b0, 1'b0, 1'b0, ModeNone,  1'b0, 1'b0,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd100,        1'b0, 1'b0, 1'b0, ModeNone,  1'b1, 1'b1,
      8'd0, 8'd0, 8'd0},
    '{ROW_TICK,  8'd0,   32'd5000,       1'b0, 1'b0, 1'b0, ModeAp,    1'b1, 1'b0,
      8'd0, 8'd0, 8'd0}
  };

  logic            clk;
  logic            rst        = 1'b1;
  logic            tick_valid = 1'b0;
  logic            tick_stall;
  sled_pkg::tick_t tick       = '0;
  logic            led_valid;
  logic            led_stall  = 1'b0;
  sled_pkg::led_t  led;
  logic            cfg_we     = 1'b0;
  logic [7:0]      cfg_data   = 8'd0;

  // predictor state
  logic [7:0]     bright_model;
  logic [31:0]    last_accept_ms;
  sled_pkg::led_t last_colour;

  sled_pkg::led_t colour_q [$];
  int unsigned    errors       = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    idle_pct     = 0;
  int unsigned    stall_pct    = 0;

  // per-request override from the directed table
  bit             row_typed  = 1'b0;
  bit             row_emits  = 1'b0;
  sled_pkg::led_t row_colour = '0;

  status_led_pattern_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .led_valid  (led_valid),
    .led_stall  (led_stall),
    .led        (led),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // triangle wave 0..255..0 over one period
  function automatic logic [7:0] wave_level(logic [31:0] now, int unsigned period);
    int unsigned phase;
    int unsigned half;
    phase = now % period;
    half  = period / 2;
    if (phase < half) return 8'((phase * sled_pkg::FullScale) / half);
    return 8'(((period - phase) * sled_pkg::FullScale) / half);
  endfunction

  function automatic logic [7:0] dimmed(logic [7:0] c);
    return 8'((32'(c) * 32'(bright_model)) / sled_pkg::FullScale);
  endfunction

  // priority pattern pick, then brightness scaling
  function automatic sled_pkg::led_t pattern_colour(sled_pkg::tick_t t);
    logic [7:0] v;
    sled_pkg::led_t c;
    if (t.flashing) begin
      v = wave_level(t.now_ms, sled_pkg::FlashPeriod);
      c = '{v, v, 8'd0};
    end else if (t.link_running) begin
      if (t.link_connected) begin
        v = wave_level(t.now_ms, sled_pkg::LinkedPeriod);
        c = '{8'd0, v, v};
      end else begin
        v = ((t.now_ms / sled_pkg::BlinkHalf) % 2 == 1) ? 8'd255 : 8'd0;
        c = '{v, 8'd0, 8'd0};
      end
    end else if (t.wireless_mode == sled_pkg::MODE_CLIENT) begin
      v = wave_level(t.now_ms, sled_pkg::StaPeriod);
      c = '{8'd0, v, 8'd0};
    end else if (t.wireless_mode == sled_pkg::MODE_AP) begin
      v = wave_level(t.now_ms, sled_pkg::ApPeriod);
      c = '{8'(v / 8'd3), 8'd0, v};
    end else begin
      v = 8'(wave_level(t.now_ms, sled_pkg::IdlePeriod) / 8'd6);
      c = '{v, v, v};
    end
    c.red   = dimmed(c.red);
    c.green = dimmed(c.green);
    c.blue  = dimmed(c.blue);
    return c;
  endfunction

  // updates the predictor state; returns 1 when a new colour goes out
  function automatic bit advance_model(sled_pkg::tick_t t, output sled_pkg::led_t c);
    logic [31:0] gap;
    c   = '0;
    gap = t.now_ms - last_accept_ms;
    if (gap < sled_pkg::AcceptGapMs) return 1'b0;
    last_accept_ms = t.now_ms;
    c = pattern_colour(t);
    if (c == last_colour) return 1'b0;
    last_colour = c;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // random receiver stall
  always @(negedge clk) begin
    led_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: predict on tick requests, check colours, watchdog
  always @(posedge clk) begin : monitor
    sled_pkg::led_t want;
    bit             fresh;
    if (rst) begin
      bright_model   = 8'(sled_pkg::BrightReset);
      last_accept_ms = '0;
      last_colour    = '0;
      quiet_cycles   = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we) bright_model = cfg_data;
      if (led_valid && !led_stall) begin
        quiet_cycles = 0;
        if (colour_q.size() == 0) begin
          errors++;
          $display("%0t: colour %0d/%0d/%0d with none expected",
                   $time, led.red, led.green, led.blue);
        end else begin
          want = colour_q.pop_front();
          check_field("red", want.red, led.red);
          check_field("green", want.green, led.green);
          check_field("blue", want.blue, led.blue);
        end
      end
      if (tick_valid && !tick_stall) begin
        quiet_cycles = 0;
        fresh = advance_model(tick, want);
        if (row_typed) begin
          fresh = row_emits;
          want  = row_colour;
        end
        if (fresh) colour_q.push_back(want);
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // entered and left at a falling edge; valid stays high into the next request
  task automatic drive_tick(sled_pkg::tick_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      tick_valid <= 1'b0;
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    do @(posedge clk); while (!(tick_valid && !tick_stall));
    @(negedge clk);
  endtask

  // hold the sender until every colour is out and the block has settled
  task automatic wait_drained();
    tick_valid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_level(logic [7:0] level);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= level;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    sled_pkg::tick_t t;
    int unsigned     pick;
    int unsigned     pat;
    int unsigned     sent;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LEVEL) begin
        write_level(plan[i].level);
      end else begin
        row_typed  = plan[i].typed;
        row_emits  = plan[i].emits;
        row_colour = '{plan[i].red, plan[i].green, plan[i].blue};
        t = '{plan[i].now, plan[i].fl, plan[i].run, plan[i].conn, plan[i].mode};
        drive_tick(t);
      end
    end
    row_typed = 1'b0;

    // random phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_level(8'd255);
        3: write_level(8'(sled_pkg::BrightReset));
        default: write_level(8'($urandom_range(1, 254)));
      endcase
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct  = 18;
          stall_pct = 18;
        end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(0, 149) == 0) wait_drained();
        // timestamp: mostly steady progress, some early, some jumps and wraps
        pick = $urandom_range(0, 99);
        if (pick < 8)
          t.now_ms = last_accept_ms + $urandom_range(0, sled_pkg::AcceptGapMs - 1);
        else if (pick < 12)
          t.now_ms = $urandom;
        else if (pick < 15)
          t.now_ms = 32'hFFFF_FFFF - $urandom_range(0, 700);
        else if (pick < 25)
          t.now_ms = last_accept_ms + $urandom_range(700, 7000);
        else
          t.now_ms = last_accept_ms + $urandom_range(sled_pkg::AcceptGapMs, 700);
        // status: one pattern chosen, don't-care bits random
        pat = $urandom_range(0, 5);
        t.flashing       = (pat == 0);
        t.link_running   = (pat == 1 || pat == 2) ? 1'b1 :
                           (pat == 0) ? 1'($urandom) : 1'b0;
        t.link_connected = (pat == 1) ? 1'b1 : (pat == 2) ? 1'b0 : 1'($urandom);
        case (pat)
          3: t.wireless_mode = ModeClient;
          4: t.wireless_mode = ModeAp;
          5: t.wireless_mode = $urandom_range(0, 1) ? ModeSpare : ModeNone;
          default: t.wireless_mode = 2'($urandom);
        endcase
        sent++;
        drive_tick(t);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sled_pkg.sv
sv/sled_div.sv
sv/status_led_pattern_generator.sv
dv/status_led_pattern_generator_tb.sv
